FILE: rtl/glzw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package glzw_pkg;

  localparam int DICT_SLOTS  = 8192;
  localparam int SLOT_W      = $clog2(DICT_SLOTS);
  localparam int MAX_CODES   = 4096;
  localparam int CODE_W      = 12;
  localparam int KEY_W       = CODE_W + 8;
  localparam int EPOCH_W     = 4;
  localparam int ENTRY_W     = EPOCH_W + KEY_W + CODE_W;
  localparam int NFC_W       = 13;
  localparam int ACC_W       = 32;
  localparam int BITS_W      = 5;

  localparam logic [CODE_W-1:0]  CODE_CLEAR  = 12'd256;
  localparam logic [CODE_W-1:0]  CODE_END    = 12'd257;
  localparam logic [NFC_W-1:0]   FIRST_FREE  = 13'd258;
  localparam logic [3:0]         START_WIDTH = 4'd9;
  localparam logic [3:0]         TOP_WIDTH   = 4'd12;
  localparam logic [15:0]        HASH_MULT   = 16'd40503;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;

  typedef enum logic [3:0] {
    ST_SWEEP_INIT,
    ST_IDLE,
    ST_START,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_FULL,
    ST_SWEEP_WRAP,
    ST_EOF_A,
    ST_EOF_B,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_CLEAR,
    SEL_END
  } code_sel_t;

  typedef struct packed {
    logic      capture;
    logic      hash;
    logic      slot_inc;
    logic      append;
    code_sel_t code_sel;
    logic      use_w9;
    logic      insert;
    logic      hit_load;
    logic      dict_reset;
    logic      epoch_bump;
    logic      take_pixel;
    logic      drain;
    logic      sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic open;
    logic rd_valid;
    logic rd_match;
    logic full;
    logic epoch_wrap;
    logic out_free;
    logic last_byte;
    logic sweep_last;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/glzw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/glzw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module glzw_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire glzw_pkg::dp_cmd_t    cmd,
  output glzw_pkg::dp_status_t      status,
  input  wire logic                 in_eof,
  input  wire logic [7:0]           in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_item_done,
  output logic                      out_frame_done
);
  import glzw_pkg::*;

  logic               eof_reg;
  logic [7:0]         pixel;
  logic [KEY_W-1:0]   key;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  sweep_cnt;
  logic [CODE_W-1:0]  prefix;
  logic [NFC_W-1:0]   nfc;
  logic [3:0]         width;
  logic [EPOCH_W-1:0] epoch;
  logic               open;
  logic [ACC_W-1:0]   acc;
  logic [BITS_W-1:0]  bits;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] rdata;

  logic [SLOT_W-1:0]  hash_prod;
  logic [CODE_W-1:0]  code_val;
  logic [3:0]         app_w;
  logic [NFC_W-1:0]   nfc_inc;
  logic [NFC_W-1:0]   width_span;
  logic               last;

  assign hash_prod  = SLOT_W'(key[SLOT_W-1:0] * HASH_MULT);
  assign nfc_inc    = nfc + NFC_W'(1);
  assign width_span = NFC_W'(1) << width;
  assign app_w      = cmd.use_w9 ? START_WIDTH : width;
  assign last       = eof_reg ? (bits <= BITS_W'(8)) : (bits < BITS_W'(16));

  always_comb begin
    case (cmd.code_sel)
      SEL_CLEAR: code_val = CODE_CLEAR;
      SEL_END:   code_val = CODE_END;
      default:   code_val = prefix;
    endcase
  end

  assign ram_we    = cmd.insert | cmd.sweep;
  assign ram_waddr = cmd.sweep ? sweep_cnt : slot;
  assign ram_wdata = cmd.sweep ? '0 : {epoch, key, nfc[CODE_W-1:0]};

  glzw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DICT_SLOTS)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      eof_reg <= in_eof;
      pixel   <= in_pixel;
      key     <= {prefix, in_pixel};
    end
    if (cmd.hash) begin
      slot <= hash_prod;
    end else if (cmd.slot_inc) begin
      slot <= slot + SLOT_W'(1);
    end
    if (cmd.drain) begin
      out_byte       <= acc[7:0];
      out_item_done  <= last;
      out_frame_done <= last & eof_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      prefix    <= '0;
      nfc       <= FIRST_FREE;
      width     <= START_WIDTH;
      epoch     <= EPOCH_FIRST;
      open      <= 1'b0;
      acc       <= '0;
      bits      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + SLOT_W'(1);
      end
      if (cmd.take_pixel) begin
        prefix <= {4'd0, pixel};
        open   <= 1'b1;
      end else if (cmd.hit_load) begin
        prefix <= rdata[CODE_W-1:0];
      end else if (cmd.drain && last && eof_reg) begin
        prefix <= '0;
        open   <= 1'b0;
      end
      if (cmd.dict_reset) begin
        nfc   <= FIRST_FREE;
        width <= START_WIDTH;
      end else if (cmd.insert) begin
        nfc <= nfc_inc;
        if ((nfc_inc > width_span) && (width < TOP_WIDTH)) begin
          width <= width + 4'd1;
        end
      end
      if (cmd.epoch_bump) begin
        epoch <= (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
      end
      if (cmd.append) begin
        acc  <= acc | (ACC_W'(code_val) << bits);
        bits <= bits + BITS_W'(app_w);
      end else if (cmd.drain) begin
        acc  <= acc >> 8;
        bits <= (bits >= BITS_W'(8)) ? bits - BITS_W'(8) : '0;
      end
      if (cmd.drain) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.open       = open;
    status.rd_valid   = rdata[ENTRY_W-1 -: EPOCH_W] == epoch;
    status.rd_match   = rdata[CODE_W +: KEY_W] == key;
    status.full       = nfc >= NFC_W'(MAX_CODES);
    status.epoch_wrap = epoch == EPOCH_LAST;
    status.out_free   = !out_valid || out_ready;
    status.last_byte  = last;
    status.sweep_last = sweep_cnt == SLOT_W'(DICT_SLOTS - 1);
  end

endmodule
`default_nettype wire

FILE: rtl/glzw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module glzw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_eof,
  output logic                      in_ready,
  input  wire glzw_pkg::dp_status_t status,
  output glzw_pkg::dp_cmd_t         cmd
);
  import glzw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.code_sel = SEL_PREFIX;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_SWEEP_INIT: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_eof) begin
            state_next = ST_EOF_A;
          end else if (status.open) begin
            state_next = ST_HASH;
          end else begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.append     = 1'b1;
        cmd.code_sel   = SEL_CLEAR;
        cmd.use_w9     = 1'b1;
        cmd.dict_reset = 1'b1;
        cmd.epoch_bump = 1'b1;
        cmd.take_pixel = 1'b1;
        state_next     = status.epoch_wrap ? ST_SWEEP_WRAP : ST_DRAIN;
      end
      ST_HASH: begin
        cmd.hash   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.rd_valid && status.rd_match) begin
          cmd.hit_load = 1'b1;
          state_next   = ST_IDLE;
        end else if (status.rd_valid) begin
          cmd.slot_inc = 1'b1;
          state_next   = ST_READ;
        end else begin
          cmd.append     = 1'b1;
          cmd.take_pixel = 1'b1;
          if (status.full) begin
            state_next = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            state_next = ST_DRAIN;
          end
        end
      end
      ST_FULL: begin
        cmd.append     = 1'b1;
        cmd.code_sel   = SEL_CLEAR;
        cmd.dict_reset = 1'b1;
        cmd.epoch_bump = 1'b1;
        state_next     = status.epoch_wrap ? ST_SWEEP_WRAP : ST_DRAIN;
      end
      ST_SWEEP_WRAP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_EOF_A: begin
        cmd.append = 1'b1;
        if (!status.open) begin
          cmd.code_sel   = SEL_CLEAR;
          cmd.use_w9     = 1'b1;
          cmd.dict_reset = 1'b1;
        end
        state_next = ST_EOF_B;
      end
      ST_EOF_B: begin
        cmd.append   = 1'b1;
        cmd.code_sel = SEL_END;
        state_next   = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          cmd.drain = 1'b1;
          if (status.last_byte) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/gif_lzw_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A pixel that extends a known string is captured, hashed and probed, one dictionary slot per probe.
// A pixel that ends a string then emits 1 or 2 output bytes; a full table adds a clear
// code, 3 bytes in all. An end of frame emits 3 or 4 bytes.
// A new pixel is taken only once the last one is done; the wait is set by the probe loop
// on the registered dictionary RAM read port and by output stalls. A wrap of the 4-bit epoch adds a sweep.
// Reset is synchronous, active high; a pass clearing all 8192 slots runs before the first item.
module gif_lzw_encoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] pixel_index
  input  wire logic       s_tuser,   // [0] cmd (1 = end of frame)
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] data_byte
  output logic            m_tuser,   // [0] item_done
  output logic            m_tlast
);
  import glzw_pkg::*;

  // The controller sequences each item: hash, probe the dictionary one slot
  // at a time, then append codes to the bit packer and drain bytes into the output
  // register, the final byte of a frame padded with zeros. Dictionary entries carry an
  // epoch tag, so emptying the dictionary is a bump of the current epoch, with a sweep
  // of all slots when the epoch wraps. The final byte of a frame is marked by m_tlast.
  dp_cmd_t    cmd;
  dp_status_t status;

  glzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_eof   (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  glzw_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_eof         (s_tuser),
    .in_pixel       (s_tdata),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (m_tdata),
    .out_item_done  (m_tuser),
    .out_frame_done (m_tlast)
  );

endmodule
`default_nettype wire
